// ----- src/text_console_writer_top_macros.svh -----
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Assertion shorthands; each expects clk and arst_n in scope.

`define TCW_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`define TCW_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tcw_pkg.sv -----
package tcw_pkg;

	localparam int COLUMNS_DEF     = 80;
	localparam int ROWS_DEF        = 25;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] TAB_CODE     = 8'd9;
	localparam logic [7:0] BLANK_RESET  = 8'd15;
	localparam logic [15:0] RESET_CELL  = {BLANK_RESET, SPACE_CODE};

	localparam int TAB_SPACES = 4;
	localparam int TAB_W      = $clog2(TAB_SPACES + 1);

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_TAB,
		CMD_NEWLINE,
		CMD_READ,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  ch;
		logic [7:0]  colour;
		logic [10:0] cell_index;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TAB,
		ST_SCROLL,
		ST_READ
	} back_state_t;

endpackage

// ----- src/tcw_if.sv -----
interface tcw_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  ch;
	logic [7:0]  colour;
	logic [10:0] cell_index;

	modport source (output valid, output op, output ch, output colour, output cell_index,
		input ready);
	modport sink (input valid, input op, input ch, input colour, input cell_index,
		output ready);
endinterface

interface tcw_rsp_if;
	logic       valid;
	logic       ready;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic [7:0] cell_char;
	logic [7:0] cell_colour;
	logic       scrolled;

	modport source (output valid, output cursor_col, output cursor_row, output cell_char,
		output cell_colour, output scrolled, input ready);
	modport sink (input valid, input cursor_col, input cursor_row, input cell_char,
		input cell_colour, input scrolled, output ready);
endinterface

// ----- src/tcw_front.sv -----
module tcw_front (
	tcw_req_if.sink        req,
	input  logic           clearing,
	input  logic           push_ready,
	output logic           push_valid,
	output tcw_pkg::cmd_t  push_data
);

	tcw_pkg::cmd_kind_t kind;

	always_comb begin
		priority if (req.op == tcw_pkg::OP_READ) begin
			kind = tcw_pkg::CMD_READ;
		end else if (req.ch == tcw_pkg::NEWLINE_CODE) begin
			kind = tcw_pkg::CMD_NEWLINE;
		end else if (req.ch == tcw_pkg::TAB_CODE) begin
			kind = tcw_pkg::CMD_TAB;
		end else if (req.ch >= tcw_pkg::SPACE_CODE) begin
			kind = tcw_pkg::CMD_PUT;
		end else begin
			kind = tcw_pkg::CMD_NOP;
		end
	end

	assign req.ready             = push_ready && !clearing;
	assign push_valid            = req.valid && !clearing;
	assign push_data.kind        = kind;
	assign push_data.ch          = req.ch;
	assign push_data.colour      = req.colour;
	assign push_data.cell_index  = req.cell_index;

endmodule

// ----- src/tcw_fifo.sv -----
module tcw_fifo #(
	parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tcw_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tcw_pkg::cmd_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcw_pkg::cmd_t     slot_q [DEPTH];
	logic [PTR_W-1:0]  wptr_q;
	logic [PTR_W-1:0]  rptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/tcw_back.sv -----
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [7:0]    cfg_wr_data,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  tcw_pkg::cmd_t cmd,
	output logic          clearing,
	tcw_rsp_if.source     rsp
);

	`include "text_console_writer_top_macros.svh"

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int TAB_W  = tcw_pkg::TAB_W;

	localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_POS = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] FIRST_SRC    = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL     = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(ROWS - 1);

	tcw_pkg::back_state_t state_q;
	tcw_pkg::back_state_t state_d;

	logic [15:0]       mem_q [CELLS];
	logic [15:0]       rd_data_q;
	logic [7:0]        blank_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic              rd_on_q;
	logic              cp_s1;
	logic [TAB_W-1:0]  tab_left_q;
	logic [7:0]        colour_q;
	logic              scr_q;

	logic              out_valid_q;
	logic [6:0]        out_col_q;
	logic [4:0]        out_row_q;
	logic [7:0]        out_char_q;
	logic [7:0]        out_colour_q;
	logic              out_scr_q;

	logic [COL_W-1:0]  col_d;
	logic [ROW_W-1:0]  row_d;
	logic [ADDR_W-1:0] pos_d;
	logic [15:0]       col_ext_d;
	logic [15:0]       row_ext_d;
	logic [15:0]       idx_ext;
	logic              mem_we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] raddr;
	logic              load;
	logic [15:0]       res_cell;
	logic              res_scr;
	logic              slot_free;
	logic              start;
	logic              in_range;
	logic              last_col;
	logic              last_row;
	logic              put_scroll;
	logic              scroll_we;
	logic              scroll_done;
	logic              scroll_start;
	logic [15:0]       blank_cell;

	assign slot_free    = !out_valid_q || rsp.ready;
	assign start        = (state_q == tcw_pkg::ST_IDLE) && cmd_valid && slot_free;
	assign cmd_ready    = start;
	assign clearing     = (state_q == tcw_pkg::ST_CLEAR);
	assign in_range     = int'(cmd.cell_index) < CELLS;
	assign idx_ext      = 16'(cmd.cell_index);
	assign last_col     = (col_q == LAST_COL);
	assign last_row     = (row_q == LAST_ROW);
	assign put_scroll   = last_col && last_row;
	assign scroll_we    = cp_s1 || !rd_on_q;
	assign scroll_done  = (state_q == tcw_pkg::ST_SCROLL) && scroll_we && (wr_ptr_q == LAST_CELL);
	assign scroll_start = (state_d == tcw_pkg::ST_SCROLL) && (state_q != tcw_pkg::ST_SCROLL);
	assign blank_cell   = {blank_q, tcw_pkg::SPACE_CODE};
	assign col_ext_d    = 16'(col_d);
	assign row_ext_d    = 16'(row_d);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				if (wr_ptr_q == LAST_CELL) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						tcw_pkg::CMD_PUT: begin
							if (put_scroll) begin
								state_d = tcw_pkg::ST_SCROLL;
							end
						end
						tcw_pkg::CMD_NEWLINE: begin
							if (last_row) begin
								state_d = tcw_pkg::ST_SCROLL;
							end
						end
						tcw_pkg::CMD_TAB: state_d = tcw_pkg::ST_TAB;
						tcw_pkg::CMD_READ: begin
							if (in_range) begin
								state_d = tcw_pkg::ST_READ;
							end
						end
						default: state_d = tcw_pkg::ST_IDLE;
					endcase
				end
			end
			tcw_pkg::ST_TAB: begin
				priority if (put_scroll) begin
					state_d = tcw_pkg::ST_SCROLL;
				end else if (tab_left_q == TAB_W'(1)) begin
					state_d = tcw_pkg::ST_IDLE;
				end else begin
					state_d = tcw_pkg::ST_TAB;
				end
			end
			tcw_pkg::ST_SCROLL: begin
				if (scroll_done) begin
					state_d = (tab_left_q != '0) ? tcw_pkg::ST_TAB : tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_READ: state_d = tcw_pkg::ST_IDLE;
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		col_d    = col_q;
		row_d    = row_q;
		pos_d    = pos_q;
		mem_we   = 1'b0;
		waddr    = wr_ptr_q;
		wdata    = blank_cell;
		mem_re   = 1'b0;
		raddr    = rd_ptr_q;
		load     = 1'b0;
		res_cell = '0;
		res_scr  = 1'b0;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				wdata  = tcw_pkg::RESET_CELL;
			end
			tcw_pkg::ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						tcw_pkg::CMD_PUT: begin
							mem_we = 1'b1;
							waddr  = pos_q;
							wdata  = {cmd.colour, cmd.ch};
							if (last_col) begin
								col_d = '0;
								if (last_row) begin
									pos_d = LAST_ROW_POS;
								end else begin
									row_d = row_q + ROW_W'(1);
									pos_d = pos_q + ADDR_W'(1);
								end
							end else begin
								col_d = col_q + COL_W'(1);
								pos_d = pos_q + ADDR_W'(1);
							end
							load = !put_scroll;
						end
						tcw_pkg::CMD_NEWLINE: begin
							col_d = '0;
							if (last_row) begin
								pos_d = LAST_ROW_POS;
							end else begin
								row_d = row_q + ROW_W'(1);
								pos_d = pos_q - ADDR_W'(col_q) + FIRST_SRC;
								load  = 1'b1;
							end
						end
						tcw_pkg::CMD_TAB: begin
						end
						tcw_pkg::CMD_READ: begin
							if (in_range) begin
								mem_re = 1'b1;
								raddr  = idx_ext[ADDR_W-1:0];
							end else begin
								load = 1'b1;
							end
						end
						default: load = 1'b1;
					endcase
				end
			end
			tcw_pkg::ST_TAB: begin
				mem_we = 1'b1;
				waddr  = pos_q;
				wdata  = {colour_q, tcw_pkg::SPACE_CODE};
				if (last_col) begin
					col_d = '0;
					if (last_row) begin
						pos_d = LAST_ROW_POS;
					end else begin
						row_d = row_q + ROW_W'(1);
						pos_d = pos_q + ADDR_W'(1);
					end
				end else begin
					col_d = col_q + COL_W'(1);
					pos_d = pos_q + ADDR_W'(1);
				end
				load    = !put_scroll && (tab_left_q == TAB_W'(1));
				res_scr = scr_q;
			end
			tcw_pkg::ST_SCROLL: begin
				mem_re = rd_on_q;
				mem_we = scroll_we;
				wdata  = cp_s1 ? rd_data_q : blank_cell;
				load    = scroll_done && (tab_left_q == '0);
				res_scr = 1'b1;
			end
			tcw_pkg::ST_READ: begin
				load     = 1'b1;
				res_cell = rd_data_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (scroll_start) begin
			rd_ptr_q <= FIRST_SRC;
		end else if ((state_q == tcw_pkg::ST_SCROLL) && rd_on_q) begin
			rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
		end
		if (start && (cmd.kind == tcw_pkg::CMD_TAB)) begin
			colour_q <= cmd.colour;
		end
		if (load) begin
			out_col_q    <= col_ext_d[6:0];
			out_row_q    <= row_ext_d[4:0];
			out_char_q   <= res_cell[7:0];
			out_colour_q <= res_cell[15:8];
			out_scr_q    <= res_scr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_CLEAR;
			blank_q     <= tcw_pkg::BLANK_RESET;
			col_q       <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			wr_ptr_q    <= '0;
			rd_on_q     <= 1'b0;
			cp_s1       <= 1'b0;
			tab_left_q  <= '0;
			scr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			pos_q   <= pos_d;
			if (cfg_wr_en) begin
				blank_q <= cfg_wr_data;
			end
			if (scroll_start) begin
				wr_ptr_q <= '0;
			end else if (state_q == tcw_pkg::ST_CLEAR) begin
				wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
			end else if ((state_q == tcw_pkg::ST_SCROLL) && scroll_we) begin
				wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
			end
			if (scroll_start) begin
				rd_on_q <= 1'b1;
			end else if ((state_q == tcw_pkg::ST_SCROLL) && (rd_ptr_q == LAST_CELL)) begin
				rd_on_q <= 1'b0;
			end
			cp_s1 <= (state_q == tcw_pkg::ST_SCROLL) && rd_on_q;
			if (start && (cmd.kind == tcw_pkg::CMD_TAB)) begin
				tab_left_q <= TAB_W'(tcw_pkg::TAB_SPACES);
			end else if (state_q == tcw_pkg::ST_TAB) begin
				tab_left_q <= tab_left_q - TAB_W'(1);
			end
			if (start) begin
				scr_q <= 1'b0;
			end else if (scroll_start) begin
				scr_q <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.cursor_col  = out_col_q;
	assign rsp.cursor_row  = out_row_q;
	assign rsp.cell_char   = out_char_q;
	assign rsp.cell_colour = out_colour_q;
	assign rsp.scrolled    = out_scr_q;

	`TCW_ASSERT_ALWAYS(a_cursor_linear, 32'(pos_q) == 32'(row_q) * 32'(COLUMNS) + 32'(col_q), "cursor position out of step with row and column")
	`TCW_ASSERT_IMPLY(a_load_slot_free, load, !out_valid_q || rsp.ready, "result overwrites an untaken result")
	`TCW_ASSERT_IMPLY(a_no_pop_in_clear, state_q == tcw_pkg::ST_CLEAR, !cmd_ready, "command taken during clearing pass")
	`TCW_ASSERT_IMPLY(a_scroll_drained, scroll_done, !rd_on_q && !cp_s1, "scroll ends with copies outstanding")
	`TCW_ASSERT_NEXT(a_scroll_armed, scroll_start, rd_on_q && (state_q == tcw_pkg::ST_SCROLL), "scroll entered without read side armed")

endmodule

// ----- src/text_console_writer_top.sv -----
// Text console writer: a screen of ROWS x COLUMNS character cells and a cursor.
// Channel req takes one item: op 0 puts ch with attribute colour at the cursor
// (newline, tab as four spaces, other control codes ignored), op 1 reads cell
// cell_index. Channel rsp returns one item per request: the cursor after the
// step, the read cell (zero for puts) and a scrolled flag.
// cfg_wr_en / cfg_wr_data set the attribute used for rows blanked by a scroll.
// Each result is held in the output register until rsp takes it. Throughput is
// set by the back-end sequencer and the single write port of the cell memory:
// the back end takes the next command only when idle and its result slot is
// free or being taken; a tab writes its four spaces in turn, and each scroll
// copies or blanks every cell one per cycle.
// After reset the cursor is top left and a clearing pass writes a space in
// attribute 15 to every cell, during which req.ready stays low; configuration
// writes are taken throughout.
// When rsp stalls, the held result waits in the output register while the
// command queue keeps taking requests until it fills, then req.ready drops.
module text_console_writer_top #(
	parameter int COLUMNS     = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS        = tcw_pkg::ROWS_DEF,
	parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	tcw_req_if.sink    req,
	tcw_rsp_if.source  rsp
);

	logic          push_valid;
	logic          push_ready;
	tcw_pkg::cmd_t push_data;
	logic          pop_valid;
	logic          pop_ready;
	tcw_pkg::cmd_t pop_data;
	logic          clearing;

	tcw_front u_front (
		.req        (req),
		.clearing   (clearing),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	tcw_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (pop_valid),
		.cmd_ready   (pop_ready),
		.cmd         (pop_data),
		.clearing    (clearing),
		.rsp         (rsp)
	);

endmodule
